[rtl/ols_pkg.sv]
// shared types and constants for the ordered list store
// no dependencies; used by every file of the block
package ols_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int OUT_COUNT_W = 5;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND       = 3'd0,
        CMD_INSERT_FRONT = 3'd1,
        CMD_REMOVE_FRONT = 3'd2,
        CMD_REMOVE_END   = 3'd3,
        CMD_DELETE_VALUE = 3'd4,
        CMD_CLEAR        = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_APPEND,
        CELL_POP_FRONT,
        CELL_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [DATA_W-1:0] key;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  last_idx;
    } cell_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic signed [DATA_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] removed_value;
        logic [OUT_COUNT_W-1:0]   count;
    } out_t;

endpackage

[rtl/ordered_list_store.sv]
// channel  | ports                      | beat
// ---------+----------------------------+-------------------------------
// input    | s_valid, s_ready, s_data   | command and value (in_t)
// result   | m_valid, m_ready, m_data   | status, removed value, count
//
// every command, delete by value included, completes in the cycle it is accepted; the
// clock is set by the key compare and the found ripple along the cell row.
// one beat per cycle is sustained while m_ready stays high.
// the output register lets a new beat in whenever it is empty or is taken.
// reset clears the count and the result valid; entries and result data need no reset.
// top level of the ordered list store; depends on ols_pkg and ols_cell
module ordered_list_store (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ols_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ols_pkg::out_t  m_data
);

    logic [ols_pkg::CNT_W-1:0]  count_reg;
    logic [ols_pkg::CNT_W-1:0]  count_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;
    ols_pkg::out_t              out_reg;
    ols_pkg::out_t              out_next;

    ols_pkg::cell_ctl_t         ctl;
    ols_pkg::cell_op_t          op;
    ols_pkg::status_t           status;
    logic [ols_pkg::DATA_W-1:0] removed;
    logic                       accept;
    logic                       full;
    logic                       empty;

    logic [ols_pkg::DATA_W-1:0] cell_value [ols_pkg::DEPTH];
    logic [ols_pkg::DATA_W-1:0] rd_chain   [ols_pkg::DEPTH+1];
    logic                       found_chain[ols_pkg::DEPTH+1];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign full  = count_reg == ols_pkg::CNT_W'(ols_pkg::DEPTH);
    assign empty = count_reg == '0;

    assign ctl.op       = accept ? op : ols_pkg::CELL_HOLD;
    assign ctl.key      = s_data.value;
    assign ctl.count    = count_reg;
    assign ctl.last_idx = count_reg - ols_pkg::CNT_W'(1);

    assign rd_chain[0]    = '0;
    assign found_chain[0] = 1'b0;

    for (genvar g = 0; g < ols_pkg::DEPTH; g++) begin : g_cell
        logic [ols_pkg::DATA_W-1:0] left_value;
        logic [ols_pkg::DATA_W-1:0] right_value;

        if (g == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_mid_l
            assign left_value = cell_value[g-1];
        end

        if (g == ols_pkg::DEPTH - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_mid_r
            assign right_value = cell_value[g+1];
        end

        ols_cell u_cell (
            .aclk        (aclk),
            .cell_idx    (ols_pkg::IDX_W'(g)),
            .ctl         (ctl),
            .left_value  (left_value),
            .right_value (right_value),
            .found_in    (found_chain[g]),
            .found_out   (found_chain[g+1]),
            .rd_in       (rd_chain[g]),
            .rd_out      (rd_chain[g+1]),
            .value       (cell_value[g])
        );
    end

    // command decode
    always_comb begin
        op         = ols_pkg::CELL_HOLD;
        status     = ols_pkg::ST_OK;
        removed    = '0;
        count_next = count_reg;
        unique case (s_data.cmd)
            ols_pkg::CMD_APPEND: begin
                if (full) begin
                    status = ols_pkg::ST_FULL;
                end else begin
                    op         = ols_pkg::CELL_APPEND;
                    count_next = count_reg + ols_pkg::CNT_W'(1);
                end
            end
            ols_pkg::CMD_INSERT_FRONT: begin
                if (full) begin
                    status = ols_pkg::ST_FULL;
                end else begin
                    op         = ols_pkg::CELL_PUSH_FRONT;
                    count_next = count_reg + ols_pkg::CNT_W'(1);
                end
            end
            ols_pkg::CMD_REMOVE_FRONT: begin
                if (empty) begin
                    status = ols_pkg::ST_EMPTY;
                end else begin
                    op         = ols_pkg::CELL_POP_FRONT;
                    removed    = cell_value[0];
                    count_next = count_reg - ols_pkg::CNT_W'(1);
                end
            end
            ols_pkg::CMD_REMOVE_END: begin
                if (empty) begin
                    status = ols_pkg::ST_EMPTY;
                end else begin
                    removed    = rd_chain[ols_pkg::DEPTH];
                    count_next = count_reg - ols_pkg::CNT_W'(1);
                end
            end
            ols_pkg::CMD_DELETE_VALUE: begin
                if (found_chain[ols_pkg::DEPTH]) begin
                    op         = ols_pkg::CELL_DELETE;
                    removed    = s_data.value;
                    count_next = count_reg - ols_pkg::CNT_W'(1);
                end else begin
                    status = ols_pkg::ST_NOT_FOUND;
                end
            end
            ols_pkg::CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
                op = ols_pkg::CELL_HOLD;
            end
        endcase
    end

    always_comb begin
        out_next.status        = status;
        out_next.removed_value = removed;
        out_next.count         = ols_pkg::OUT_COUNT_W'(count_next);
        m_valid_next           = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= out_next;
        end
    end

endmodule

[rtl/ols_cell.sv]
// one list entry: holds a value, compares it against the search key and
// shifts toward either neighbor; depends on ols_pkg
module ols_cell (
    input  logic                          aclk,
    input  logic [ols_pkg::IDX_W-1:0]     cell_idx,
    input  ols_pkg::cell_ctl_t            ctl,
    input  logic [ols_pkg::DATA_W-1:0]    left_value,
    input  logic [ols_pkg::DATA_W-1:0]    right_value,
    input  logic                          found_in,
    output logic                          found_out,
    input  logic [ols_pkg::DATA_W-1:0]    rd_in,
    output logic [ols_pkg::DATA_W-1:0]    rd_out,
    output logic [ols_pkg::DATA_W-1:0]    value
);

    logic [ols_pkg::DATA_W-1:0] value_reg;
    logic [ols_pkg::DATA_W-1:0] value_next;
    logic                       live;
    logic                       hit;
    logic                       at_end;

    assign live      = ols_pkg::CNT_W'(cell_idx) < ctl.count;
    assign hit       = live && (value_reg == ctl.key);
    // ripple: set once any cell at or before this one matched
    assign found_out = found_in | hit;
    assign at_end    = ols_pkg::CNT_W'(cell_idx) == ctl.last_idx;
    assign rd_out    = rd_in | (at_end ? value_reg : '0);
    assign value     = value_reg;

    always_comb begin
        value_next = value_reg;
        case (ctl.op)
            ols_pkg::CELL_PUSH_FRONT: begin
                value_next = (cell_idx == '0) ? ctl.key : left_value;
            end
            ols_pkg::CELL_APPEND: begin
                if (ols_pkg::CNT_W'(cell_idx) == ctl.count) begin
                    value_next = ctl.key;
                end
            end
            ols_pkg::CELL_POP_FRONT: begin
                value_next = right_value;
            end
            ols_pkg::CELL_DELETE: begin
                // the matching cell and all behind it close the gap
                if (found_out) begin
                    value_next = right_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

[rtl/ols_checker.sv]
// port-level checks for the ordered list store, bound to its top level
// depends on ols_pkg and ordered_list_store
module ols_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input ols_pkg::out_t  m_data
);

    // a stalled input beat stays offered
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input beat withdrawn while stalled");

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ols_pkg::ST_EMPTY) |->
            (m_data.count == '0) && (m_data.removed_value == '0))
        else $error("empty status with entries or removed value");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ols_pkg::ST_FULL) |->
            (m_data.count == ols_pkg::OUT_COUNT_W'(ols_pkg::DEPTH)) &&
            (m_data.removed_value == '0))
        else $error("full status with wrong count or removed value");

endmodule

bind ordered_list_store ols_checker u_ols_checker (.*);
